FILE: src/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 path decoder.
package u8u16_pkg;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned UNIT_W = 16;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CP_W-1:0]   MAX_CODE_POINT = 21'h10FFFF;
    localparam logic [CP_W-1:0]   BMP_LIMIT      = 21'h010000;
    localparam logic [CP_W-1:0]   SLASH_CP       = 21'h00002F;
    localparam logic [CP_W-1:0]   BACKSLASH_CP   = 21'h00005C;
    localparam logic [UNIT_W-1:0] SURR_HI_OFFSET = 16'hD7C0;
    localparam logic [UNIT_W-1:0] SURR_LO_BASE   = 16'hDC00;

    localparam logic [BYTE_W-1:0] LEAD_MIN      = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD_3B_START = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4B_START = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_END      = 8'hF8;

    // One result item.
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              run_last;
        logic              error;
        logic              string_end;
    } result_t;

    // What the decoder produces for one input item: zero, one or two results.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } dec_out_t;

endpackage

FILE: src/u8u16_decode.sv
// Byte decoder: holds the per-string state and turns one byte into its results.
module u8u16_decode
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [u8u16_pkg::BYTE_W-1:0] in_byte,
    input  logic                         end_of_string,
    input  logic                         map_slash,
    output u8u16_pkg::dec_out_t          dec_out
);

    logic [u8u16_pkg::CP_W-1:0] acc_reg, acc_next;
    logic [1:0]                 rem_reg, rem_next;
    logic                       disc_reg, disc_next;

    logic [u8u16_pkg::CP_W-1:0] cp;
    logic [u8u16_pkg::CP_W-1:0] cp_mapped;
    logic                       emit;
    logic                       err;

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        disc_next = disc_reg;
        cp        = '0;
        cp_mapped = '0;
        emit      = 1'b0;
        err       = 1'b0;
        dec_out   = '0;

        if (disc_reg)
        begin
            if (end_of_string)
            begin
                disc_next = 1'b0;
            end
        end
        else if (rem_reg != 2'd0)
        begin
            if (in_byte[7:6] != 2'b10)
            begin
                err = 1'b1;
            end
            else
            begin
                cp = {acc_reg[u8u16_pkg::CP_W-7:0], in_byte[5:0]};
                if (rem_reg == 2'd1)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    acc_next = cp;
                    rem_next = rem_reg - 2'd1;
                    err      = end_of_string;
                end
            end
        end
        else
        begin
            if (!in_byte[7])
            begin
                cp   = {{(u8u16_pkg::CP_W-u8u16_pkg::BYTE_W){1'b0}}, in_byte};
                emit = 1'b1;
            end
            else if (in_byte < u8u16_pkg::LEAD_MIN || in_byte >= u8u16_pkg::LEAD_END)
            begin
                err = 1'b1;
            end
            else
            begin
                if (in_byte < u8u16_pkg::LEAD_3B_START)
                begin
                    acc_next = {{(u8u16_pkg::CP_W-5){1'b0}}, in_byte[4:0]};
                    rem_next = 2'd1;
                end
                else if (in_byte < u8u16_pkg::LEAD_4B_START)
                begin
                    acc_next = {{(u8u16_pkg::CP_W-4){1'b0}}, in_byte[3:0]};
                    rem_next = 2'd2;
                end
                else
                begin
                    acc_next = {{(u8u16_pkg::CP_W-3){1'b0}}, in_byte[2:0]};
                    rem_next = 2'd3;
                end
                err = end_of_string;
            end
        end

        if (emit)
        begin
            acc_next = '0;
            rem_next = 2'd0;
            if (cp > u8u16_pkg::MAX_CODE_POINT)
            begin
                err = 1'b1;
            end
            else
            begin
                cp_mapped = (map_slash && cp == u8u16_pkg::SLASH_CP) ?
                            u8u16_pkg::BACKSLASH_CP : cp;
                if (cp_mapped < u8u16_pkg::BMP_LIMIT)
                begin
                    dec_out.count = 2'd1;
                    dec_out.res0  = '{code_unit:  cp_mapped[u8u16_pkg::UNIT_W-1:0],
                                      run_last:   1'b1,
                                      error:      1'b0,
                                      string_end: end_of_string};
                end
                else
                begin
                    // Surrogate pair: the high half never closes the string.
                    dec_out.count = 2'd2;
                    dec_out.res0  = '{code_unit:  {5'd0, cp_mapped[20:10]} +
                                                  u8u16_pkg::SURR_HI_OFFSET,
                                      run_last:   1'b0,
                                      error:      1'b0,
                                      string_end: 1'b0};
                    dec_out.res1  = '{code_unit:  u8u16_pkg::SURR_LO_BASE |
                                                  {6'd0, cp_mapped[9:0]},
                                      run_last:   1'b1,
                                      error:      1'b0,
                                      string_end: end_of_string};
                end
            end
        end

        if (err)
        begin
            dec_out.count = 2'd1;
            dec_out.res0  = '{code_unit:  '0,
                              run_last:   1'b1,
                              error:      1'b1,
                              string_end: end_of_string};
            dec_out.res1  = '0;
            acc_next      = '0;
            rem_next      = 2'd0;
            disc_next     = !end_of_string;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rem_reg  <= 2'd0;
            disc_reg <= 1'b0;
        end
        else if (step)
        begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            disc_reg <= disc_next;
        end
    end

    // Entering the discard state always clears any partial sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> (rem_reg == 2'd0 && acc_reg == '0))
    else $error("discarding with a partial sequence held");

endmodule

FILE: src/u8u16_outq.sv
// Two-entry result queue between the decoder and the output stream.
module u8u16_outq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                offer,
    input  u8u16_pkg::dec_out_t dec_out,
    output logic                take,
    output logic                head_valid,
    output u8u16_pkg::result_t  head,
    input  logic                pop_ready
);

    u8u16_pkg::result_t ent_reg  [2];
    u8u16_pkg::result_t ent_next [2];
    logic [1:0]         cnt_reg, cnt_next;
    logic [1:0]         after_pop;
    logic               pop;

    assign head_valid = (cnt_reg != 2'd0);
    assign head       = ent_reg[0];
    assign pop        = head_valid && pop_ready;
    assign after_pop  = cnt_reg - {1'b0, pop};
    assign take       = offer && ({1'b0, after_pop} + {1'b0, dec_out.count} <= 3'd2);

    always_comb
    begin
        ent_next[0] = pop ? ent_reg[1] : ent_reg[0];
        ent_next[1] = ent_reg[1];
        cnt_next    = after_pop;
        if (take)
        begin
            cnt_next = after_pop + dec_out.count;
            if (after_pop == 2'd0)
            begin
                ent_next[0] = dec_out.res0;
                ent_next[1] = dec_out.res1;
            end
            else if (after_pop == 2'd1 && dec_out.count != 2'd0)
            begin
                ent_next[1] = dec_out.res0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
    else $error("result queue overfilled");

endmodule

FILE: src/utf8_to_utf16_path_decoder_core.sv
// Top level of the UTF-8 to UTF-16 path decoder with optional slash mapping.
// A byte accepted on s_* is held in the input register, and its results are written
// into the result queue, whose head drives m_*.
// The block takes one byte per cycle while m_tready is high; a surrogate pair needs four
// input bytes, so its two items drain through the two-entry queue without a stall.
// Reset (rst_n low, asynchronous) empties both stages, clears the decode state
// and sets map_slash to 1.
module utf8_to_utf16_path_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: map_slash register.
    input  logic        cfg_we,
    input  logic        cfg_wdata,

    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_string

    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic [1:0]  m_tuser,   // [0] run_last, [1] error
    output logic        m_tlast    // string_end
);

    logic                             map_slash_reg;
    logic                             in_valid_reg;
    logic [u8u16_pkg::BYTE_W-1:0]     in_byte_reg;
    logic                             in_eos_reg;
    logic                             in_fire;
    logic                             dec_take;
    u8u16_pkg::dec_out_t              dec_out;
    u8u16_pkg::result_t               head;

    // The user must write the slash mapping register only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_slash_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            map_slash_reg <= cfg_wdata;
        end
    end

    // The input register moves into decode whenever the result queue has room
    // for everything this byte produces; a byte with no result always moves.
    assign in_fire  = in_valid_reg && dec_take;
    assign s_tready = !in_valid_reg || in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    // Decode state advances only when the held byte is consumed.
    u8u16_decode u_decode
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (in_fire),
        .in_byte       (in_byte_reg),
        .end_of_string (in_eos_reg),
        .map_slash     (map_slash_reg),
        .dec_out       (dec_out)
    );

    // The result queue decouples a stalled output from the input side.
    u8u16_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .offer      (in_valid_reg),
        .dec_out    (dec_out),
        .take       (dec_take),
        .head_valid (m_tvalid),
        .head       (head),
        .pop_ready  (m_tready)
    );

    assign m_tdata = head.code_unit;
    assign m_tuser = {head.error, head.run_last};
    assign m_tlast = head.string_end;

    // An error item carries no code unit and always ends its byte's run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && m_tdata == 16'h0000))
    else $error("malformed error item");

    // Only a high surrogate half leaves a run open, and it never ends a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[15:10] == 6'b110110 && !m_tlast && !m_tuser[1]))
    else $error("open run on a non high-surrogate item");

endmodule
